// File: hdl/crce_pkg.sv
`default_nettype none

package crce_pkg;

  // table geometry and field widths
  localparam int CRCE_MAX_CUSTOMERS = 64;
  localparam int CRCE_INDEX_W       = 6;
  localparam int CRCE_COORD_W       = 16;
  localparam int CRCE_DEMAND_W      = 16;
  localparam int CRCE_CAP_W         = 18;
  localparam int CRCE_DIST_W        = 24;
  localparam int CRCE_ROUTES_W      = 7;
  localparam int CRCE_LEG_W         = 17;
  localparam int CRCE_ENTRY_W       = 2 * CRCE_COORD_W + CRCE_DEMAND_W;

  // configuration register indexes
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_DEPOT_X  = 2'd1;
  localparam logic [1:0] CFG_DEPOT_Y  = 2'd2;

  localparam logic [CRCE_CAP_W-1:0]    CAPACITY_RESET = 18'd81920;
  localparam logic [CRCE_DIST_W-1:0]   DIST_MAX       = 24'hFFFFFF;
  localparam logic [CRCE_ROUTES_W-1:0] ROUTES_MAX     = 7'd127;

  // item operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_VISIT = 1'b1;

  // request to the distance unit
  typedef struct packed {
    logic                    start;
    logic [CRCE_COORD_W-1:0] ax;
    logic [CRCE_COORD_W-1:0] ay;
    logic [CRCE_COORD_W-1:0] bx;
    logic [CRCE_COORD_W-1:0] by;
  } leg_req_t;

  // answer from the distance unit
  typedef struct packed {
    logic                  done;
    logic [CRCE_LEG_W-1:0] leg_len;
  } leg_rsp_t;

endpackage

`default_nettype wire

// File: hdl/crce_ram.sv
`default_nettype none

module crce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/crce_leg_unit.sv
`default_nettype none

module crce_leg_unit
  import crce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire leg_req_t req,
  output leg_rsp_t      rsp
);

  localparam logic [2:0] LS_IDLE = 3'd0;
  localparam logic [2:0] LS_SQX  = 3'd1;
  localparam logic [2:0] LS_SQY  = 3'd2;
  localparam logic [2:0] LS_SUM  = 3'd3;
  localparam logic [2:0] LS_ROOT = 3'd4;

  localparam int SQ_W   = 2 * CRCE_COORD_W;
  localparam int RAD_W  = 2 * CRCE_LEG_W;
  localparam int REM_W  = CRCE_LEG_W + 2;
  localparam int SH_W   = REM_W + 2;
  localparam logic [4:0] LAST_STEP = 5'(CRCE_LEG_W - 1);

  logic [2:0]              state_r, state_nxt;
  logic [CRCE_COORD_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]         px_r, px_nxt, prod;
  logic [CRCE_COORD_W-1:0] mul_op;
  logic [RAD_W-1:0]        rad_r, rad_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [CRCE_LEG_W-1:0]   root_r, root_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [SH_W-1:0]         rem_sh, trial;

  // one shared squarer
  assign mul_op = (state_r == LS_SQX) ? dx_r : dy_r;
  assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);

  // restoring square root, one result bit a step
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = SH_W'({root_r, 2'b01});

  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    px_nxt    = px_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      LS_IDLE: begin
        if (req.start) begin
          dx_nxt    = (req.ax > req.bx) ? req.ax - req.bx : req.bx - req.ax;
          dy_nxt    = (req.ay > req.by) ? req.ay - req.by : req.by - req.ay;
          state_nxt = LS_SQX;
        end
      end
      LS_SQX: begin
        px_nxt    = prod;
        state_nxt = LS_SQY;
      end
      LS_SQY: begin
        rad_nxt   = RAD_W'(prod);
        state_nxt = LS_SUM;
      end
      LS_SUM: begin
        rad_nxt   = RAD_W'(rad_r) + RAD_W'(px_r);
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = LS_ROOT;
      end
      LS_ROOT: begin
        // remainder never exceeds twice the partial root, so it fits REM_W
        if (rem_sh >= trial) begin
          rem_nxt  = REM_W'(rem_sh - trial);
          root_nxt = {root_r[CRCE_LEG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem_sh);
          root_nxt = {root_r[CRCE_LEG_W-2:0], 1'b0};
        end
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          done_nxt  = 1'b1;
          state_nxt = LS_IDLE;
        end
      end
      default: begin
        state_nxt = LS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    px_r   <= px_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.leg_len = root_r;

endmodule

`default_nettype wire

// File: hdl/capacitated_route_cost_evaluator_core.sv
`default_nettype none

// Route cost evaluator for one vehicle tour, split greedily by capacity.
// Input channel (in_valid/in_ready): a load item writes coordinates and
// demand of one customer into the table, and the input stays ready. A visit
// item reads the customer back and then runs one to three legs through the
// distance unit, each a square sum over one shared multiplier and a
// 17-step square root. How long a visit takes is set by the number of legs
// it needs and the result hand-over on a final visit; the square root loop
// dominates.
// Only one item is in flight at a time.
// Result channel (out_valid/out_ready): a visit marked last_visit gives one
// item with total distance, route count and the overflow flag, held in an
// output register until taken. While it waits, load and visit items are
// still accepted; only a further final visit holds until the register is
// free. The tour accumulators clear as the result enters that register.
// Configuration (cfg_we, cfg_index, cfg_data) writes capacity or one depot
// coordinate, chosen by cfg_index. Reset is synchronous, active low: capacity returns to
// its default, depot to zero, no route open. The customer table holds no
// reset value; visit only customers that were loaded.
module capacitated_route_cost_evaluator_core
  import crce_pkg::*;
#(
  parameter int MAX_CUSTOMERS = CRCE_MAX_CUSTOMERS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_operation,
  input  wire logic [CRCE_INDEX_W-1:0]  in_customer_index,
  input  wire logic [CRCE_COORD_W-1:0]  in_coord_x,
  input  wire logic [CRCE_COORD_W-1:0]  in_coord_y,
  input  wire logic [CRCE_DEMAND_W-1:0] in_demand,
  input  wire logic                     in_last_visit,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CRCE_DIST_W-1:0]        out_total_distance,
  output logic [CRCE_ROUTES_W-1:0]      out_route_count,
  output logic                          out_demand_overflow,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CRCE_CAP_W-1:0]    cfg_data
);

  localparam int AW        = $clog2(MAX_CUSTOMERS);
  localparam int IDX_DEPTH = 1 << CRCE_INDEX_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_READ     = 3'd1;
  localparam logic [2:0] ST_LEG_GO   = 3'd2;
  localparam logic [2:0] ST_LEG_WAIT = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  // leg endpoints: depot, previous stop, current customer
  localparam logic [1:0] LEG_DC = 2'd0;
  localparam logic [1:0] LEG_PC = 2'd1;
  localparam logic [1:0] LEG_PD = 2'd2;
  localparam logic [1:0] LEG_CD = 2'd3;

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               leg_sel_r, leg_sel_nxt;
  logic                     last_r, last_nxt;
  logic [CRCE_CAP_W-1:0]    cap_r;
  logic [CRCE_COORD_W-1:0]  depot_x_r, depot_y_r;
  logic [CRCE_COORD_W-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CRCE_COORD_W-1:0]  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [CRCE_CAP_W-1:0]    load_r, load_nxt;
  logic                     open_r, open_nxt;
  logic [CRCE_DIST_W-1:0]   sum_r, sum_nxt;
  logic [CRCE_ROUTES_W-1:0] routes_r, routes_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CRCE_DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [CRCE_ROUTES_W-1:0] out_routes_r, out_routes_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic [AW-1:0]            idx_mod [0:IDX_DEPTH-1];
  logic                     ram_we;
  logic [CRCE_ENTRY_W-1:0]  ram_rdata;
  logic [CRCE_COORD_W-1:0]  rd_x, rd_y;
  logic [CRCE_DEMAND_W-1:0] rd_dem;
  logic [CRCE_CAP_W:0]      load_sum;
  logic                     fits;
  logic [CRCE_DIST_W:0]     sum_ext;
  logic [CRCE_ROUTES_W-1:0] routes_inc;
  logic                     in_acc;
  leg_req_t                 leg_req;
  leg_rsp_t                 leg_rsp;

  // customer index folded onto the table depth
  for (genvar g = 0; g < IDX_DEPTH; g++) begin : g_idx
    assign idx_mod[g] = AW'(g % MAX_CUSTOMERS);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ram_we   = in_acc && (in_operation == OP_LOAD);

  crce_ram #(
    .WIDTH(CRCE_ENTRY_W),
    .DEPTH(MAX_CUSTOMERS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (idx_mod[in_customer_index]),
    .wdata({in_coord_x, in_coord_y, in_demand}),
    .rdata(ram_rdata)
  );

  assign rd_x   = ram_rdata[CRCE_ENTRY_W-1 -: CRCE_COORD_W];
  assign rd_y   = ram_rdata[CRCE_DEMAND_W +: CRCE_COORD_W];
  assign rd_dem = ram_rdata[CRCE_DEMAND_W-1:0];

  // capacity test for joining the open route
  assign load_sum   = (CRCE_CAP_W+1)'(load_r) + (CRCE_CAP_W+1)'(rd_dem);
  assign fits       = open_r && (load_r <= cap_r) &&
                      (load_sum <= (CRCE_CAP_W+1)'(cap_r));
  assign routes_inc = (routes_r < ROUTES_MAX) ? routes_r + 7'd1 : routes_r;

  // saturating distance accumulation
  assign sum_ext = (CRCE_DIST_W+1)'(sum_r) + (CRCE_DIST_W+1)'(leg_rsp.leg_len);

  // leg operand selection
  always_comb begin
    leg_req.start = (state_r == ST_LEG_GO);
    case (leg_sel_r)
      LEG_DC: begin
        leg_req.ax = depot_x_r; leg_req.ay = depot_y_r;
        leg_req.bx = cur_x_r;   leg_req.by = cur_y_r;
      end
      LEG_PC: begin
        leg_req.ax = prev_x_r;  leg_req.ay = prev_y_r;
        leg_req.bx = cur_x_r;   leg_req.by = cur_y_r;
      end
      LEG_PD: begin
        leg_req.ax = prev_x_r;  leg_req.ay = prev_y_r;
        leg_req.bx = depot_x_r; leg_req.by = depot_y_r;
      end
      default: begin
        leg_req.ax = cur_x_r;   leg_req.ay = cur_y_r;
        leg_req.bx = depot_x_r; leg_req.by = depot_y_r;
      end
    endcase
  end

  crce_leg_unit u_leg (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (leg_req),
    .rsp  (leg_rsp)
  );

  // visit sequencer
  always_comb begin
    state_nxt      = state_r;
    leg_sel_nxt    = leg_sel_r;
    last_nxt       = last_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    load_nxt       = load_r;
    open_nxt       = open_r;
    sum_nxt        = sum_r;
    routes_nxt     = routes_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_dist_nxt   = out_dist_r;
    out_routes_nxt = out_routes_r;
    out_ovf_nxt    = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_VISIT)) begin
          last_nxt  = in_last_visit;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cur_x_nxt = rd_x;
        cur_y_nxt = rd_y;
        if (CRCE_CAP_W'(rd_dem) > cap_r) begin
          ovf_nxt = 1'b1;
        end
        if (!open_r) begin
          leg_sel_nxt = LEG_DC;
          routes_nxt  = routes_inc;
          load_nxt    = CRCE_CAP_W'(rd_dem);
          open_nxt    = 1'b1;
        end else if (fits) begin
          leg_sel_nxt = LEG_PC;
          load_nxt    = CRCE_CAP_W'(load_sum);
        end else begin
          leg_sel_nxt = LEG_PD;
          routes_nxt  = routes_inc;
          load_nxt    = CRCE_CAP_W'(rd_dem);
        end
        state_nxt = ST_LEG_GO;
      end
      ST_LEG_GO: begin
        state_nxt = ST_LEG_WAIT;
      end
      ST_LEG_WAIT: begin
        if (leg_rsp.done) begin
          sum_nxt = (sum_ext > (CRCE_DIST_W+1)'(DIST_MAX)) ? DIST_MAX
                                                           : CRCE_DIST_W'(sum_ext);
          if (leg_sel_r == LEG_PD) begin
            leg_sel_nxt = LEG_DC;
            state_nxt   = ST_LEG_GO;
          end else if (leg_sel_r == LEG_CD) begin
            state_nxt = ST_EMIT;
          end else if (last_r) begin
            leg_sel_nxt = LEG_CD;
            state_nxt   = ST_LEG_GO;
          end else begin
            prev_x_nxt = cur_x_r;
            prev_y_nxt = cur_y_r;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        // hand the tour result over and start the next tour clean
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = sum_r;
          out_routes_nxt = routes_r;
          out_ovf_nxt    = ovf_r;
          sum_nxt        = '0;
          routes_nxt     = '0;
          ovf_nxt        = 1'b0;
          load_nxt       = '0;
          open_nxt       = 1'b0;
          prev_x_nxt     = '0;
          prev_y_nxt     = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and tour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      load_r      <= '0;
      open_r      <= 1'b0;
      sum_r       <= '0;
      routes_r    <= '0;
      ovf_r       <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
      open_r      <= open_nxt;
      sum_r       <= sum_nxt;
      routes_r    <= routes_nxt;
      ovf_r       <= ovf_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAPACITY_RESET;
      depot_x_r <= '0;
      depot_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r     <= cfg_data;
        CFG_DEPOT_X:  depot_x_r <= cfg_data[CRCE_COORD_W-1:0];
        CFG_DEPOT_Y:  depot_y_r <= cfg_data[CRCE_COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    leg_sel_r    <= leg_sel_nxt;
    last_r       <= last_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    out_dist_r   <= out_dist_nxt;
    out_routes_r <= out_routes_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_total_distance  = out_dist_r;
  assign out_route_count     = out_routes_r;
  assign out_demand_overflow = out_ovf_r;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
  import crce_pkg::*;

  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                     op;
    logic [CRCE_INDEX_W-1:0]  idx;
    logic [CRCE_COORD_W-1:0]  x;
    logic [CRCE_COORD_W-1:0]  y;
    logic [CRCE_DEMAND_W-1:0] dem;
    logic                     last;
  } tour_item_t;

  typedef struct packed {
    logic [CRCE_DIST_W-1:0]   total;
    logic [CRCE_ROUTES_W-1:0] routes;
    logic                     overflow;
  } tour_score_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid          = 1'b0;
  logic                     in_ready;
  logic                     in_operation      = OP_LOAD;
  logic [CRCE_INDEX_W-1:0]  in_customer_index = '0;
  logic [CRCE_COORD_W-1:0]  in_coord_x        = '0;
  logic [CRCE_COORD_W-1:0]  in_coord_y        = '0;
  logic [CRCE_DEMAND_W-1:0] in_demand         = '0;
  logic                     in_last_visit     = 1'b0;
  logic                     out_valid;
  logic                     out_ready         = 1'b0;
  logic [CRCE_DIST_W-1:0]   out_total_distance;
  logic [CRCE_ROUTES_W-1:0] out_route_count;
  logic                     out_demand_overflow;
  logic                     cfg_we            = 1'b0;
  logic [1:0]               cfg_index         = CFG_CAPACITY;
  logic [CRCE_CAP_W-1:0]    cfg_data          = '0;

  // predicted block state
  logic [CRCE_CAP_W-1:0]    cap_q     = CAPACITY_RESET;
  logic [CRCE_COORD_W-1:0]  depot_x_q = '0;
  logic [CRCE_COORD_W-1:0]  depot_y_q = '0;
  logic [CRCE_COORD_W-1:0]  tbl_x   [CRCE_MAX_CUSTOMERS];
  logic [CRCE_COORD_W-1:0]  tbl_y   [CRCE_MAX_CUSTOMERS];
  logic [CRCE_DEMAND_W-1:0] tbl_dem [CRCE_MAX_CUSTOMERS];
  logic [CRCE_CAP_W-1:0]    load_acc      = '0;
  logic [CRCE_COORD_W-1:0]  prev_x        = '0;
  logic [CRCE_COORD_W-1:0]  prev_y        = '0;
  logic                     tour_open     = 1'b0;
  logic [CRCE_DIST_W-1:0]   dist_acc      = '0;
  logic [CRCE_ROUTES_W-1:0] route_tally   = '0;
  logic                     overflow_flag = 1'b0;

  tour_score_t pending_scores[$];

  // customers written so far, the only ones ever visited
  bit loaded [CRCE_MAX_CUSTOMERS];
  int loaded_list[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int n_items        = 0;
  int n_loads        = 0;
  int n_visits       = 0;
  int n_scores       = 0;
  int n_cfg_writes   = 0;
  int n_settings     = 0;
  int n_mismatch     = 0;

  capacitated_route_cost_evaluator_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_customer_index   (in_customer_index),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_demand           (in_demand),
    .in_last_visit       (in_last_visit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_total_distance  (out_total_distance),
    .out_route_count     (out_route_count),
    .out_demand_overflow (out_demand_overflow),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // floor square root, one result bit per step
  function automatic logic [CRCE_LEG_W-1:0] int_sqrt(input longint unsigned v);
    logic [CRCE_LEG_W-1:0] r;
    longint unsigned t;
    r = '0;
    for (int b = CRCE_LEG_W - 1; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (t * t <= v) r = t[CRCE_LEG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CRCE_LEG_W-1:0] leg_length(input logic [15:0] ax, ay, bx, by);
    logic [15:0] dx, dy;
    longint unsigned ux, uy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    ux = dx;
    uy = dy;
    return int_sqrt(ux * ux + uy * uy);
  endfunction

  // saturating distance sum
  function automatic void add_leg(input logic [15:0] ax, ay, bx, by);
    logic [CRCE_DIST_W:0] s;
    s = {1'b0, dist_acc} + leg_length(ax, ay, bx, by);
    dist_acc = (s > DIST_MAX) ? DIST_MAX : s[CRCE_DIST_W-1:0];
  endfunction

  function automatic void bump_routes();
    if (route_tally < ROUTES_MAX) route_tally = route_tally + 1'b1;
  endfunction

  // greedy split of one visit; gives a score when the tour ends
  function automatic bit score_visit(input logic [CRCE_INDEX_W-1:0] idx, input logic last,
                                     output tour_score_t s);
    logic [15:0] cx, cy, dem;
    s   = '0;
    cx  = tbl_x[idx];
    cy  = tbl_y[idx];
    dem = tbl_dem[idx];
    if (dem > cap_q) overflow_flag = 1'b1;
    if (!tour_open) begin
      add_leg(depot_x_q, depot_y_q, cx, cy);
      bump_routes();
      load_acc  = 18'(dem);
      tour_open = 1'b1;
    end else if (load_acc <= cap_q && (32'(load_acc) + 32'(dem)) <= 32'(cap_q)) begin
      add_leg(prev_x, prev_y, cx, cy);
      load_acc = load_acc + 18'(dem);
    end else begin
      add_leg(prev_x, prev_y, depot_x_q, depot_y_q);
      add_leg(depot_x_q, depot_y_q, cx, cy);
      bump_routes();
      load_acc = 18'(dem);
    end
    prev_x = cx;
    prev_y = cy;
    if (!last) return 1'b0;
    add_leg(cx, cy, depot_x_q, depot_y_q);
    s.total       = dist_acc;
    s.routes      = route_tally;
    s.overflow    = overflow_flag;
    tour_open     = 1'b0;
    load_acc      = '0;
    prev_x        = '0;
    prev_y        = '0;
    dist_acc      = '0;
    route_tally   = '0;
    overflow_flag = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // result check, register writes and prediction, all on the rising edge
  always @(posedge clk) begin
    tour_score_t got, want;
    bit produced;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_total_distance, out_route_count, out_demand_overflow};
        if (pending_scores.size() == 0) begin
          note_mismatch($sformatf("unexpected score distance %0d routes %0d overflow %0d",
                                  got.total, got.routes, got.overflow));
        end else begin
          want = pending_scores.pop_front();
          n_scores++;
          if (got.total !== want.total || got.routes !== want.routes ||
              got.overflow !== want.overflow)
            note_mismatch($sformatf(
              "expected distance %0d routes %0d overflow %0d, got %0d %0d %0d",
              want.total, want.routes, want.overflow, got.total, got.routes, got.overflow));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap_q     = cfg_data;
          CFG_DEPOT_X:  depot_x_q = cfg_data[CRCE_COORD_W-1:0];
          CFG_DEPOT_Y:  depot_y_q = cfg_data[CRCE_COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_LOAD) begin
          n_loads++;
          tbl_x[in_customer_index]   = in_coord_x;
          tbl_y[in_customer_index]   = in_coord_y;
          tbl_dem[in_customer_index] = in_demand;
        end else begin
          n_visits++;
          produced = score_visit(in_customer_index, in_last_visit, want);
          if (produced) pending_scores.push_back(want);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no accepted input item and no taken result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d scores outstanding", pending_scores.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input tour_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_operation      <= it.op;
    in_customer_index <= it.idx;
    in_coord_x        <= it.x;
    in_coord_y        <= it.y;
    in_demand         <= it.dem;
    in_last_visit     <= it.last;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  task automatic load_entry(input logic [CRCE_INDEX_W-1:0] idx, input logic [15:0] x, y, dem,
                            input logic last);
    send_item('{OP_LOAD, idx, x, y, dem, last});
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(int'(idx));
    end
  endtask

  // coordinates and demand are ignored on a visit, so they carry noise
  task automatic visit_customer(input logic [CRCE_INDEX_W-1:0] idx, input logic last);
    send_item('{OP_VISIT, idx, 16'($urandom), 16'($urandom), 16'($urandom), last});
  endtask

  task automatic wait_until_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [17:0] cap, input logic [15:0] dx, dy);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    @(negedge clk);
    cfg_index <= CFG_DEPOT_X;
    cfg_data  <= 18'(dx);
    @(negedge clk);
    cfg_index <= CFG_DEPOT_Y;
    cfg_data  <= 18'(dy);
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_cfg_writes += 3;
    n_settings++;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 62; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default:       begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_demand();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(20000));
      4:       return 16'($urandom_range(2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CRCE_INDEX_W-1:0] pick_loaded();
    return 6'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic load_random_entry();
    load_entry(6'($urandom_range(63)), pick_coord(), pick_coord(), pick_demand(),
               1'($urandom_range(1)));
  endtask

  // defaults after reset: a lone far customer, then a route that just fits
  task automatic test_reset_defaults();
    load_entry(6'd0,  16'd0,     16'd0,     16'd0,     1'b1);
    load_entry(6'd63, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0);
    load_entry(6'd1,  16'd32768, 16'd0,     16'd40000, 1'b0);
    load_entry(6'd2,  16'd0,     16'd32768, 16'd40000, 1'b0);
    visit_customer(6'd63, 1'b1);
    visit_customer(6'd1,  1'b0);
    visit_customer(6'd2,  1'b0);
    visit_customer(6'd0,  1'b1);
  endtask

  // load equal to capacity, oversized demand, table writes inside a tour
  task automatic test_capacity_boundaries();
    load_entry(6'd4, 16'd50000, 16'd50000, 16'd20000, 1'b0);
    load_entry(6'd3, 16'd1000,  16'd2000,  16'hFFFF,  1'b0);
    visit_customer(6'd4, 1'b0);
    visit_customer(6'd4, 1'b0);
    visit_customer(6'd4, 1'b0);
    visit_customer(6'd3, 1'b0);
    visit_customer(6'd4, 1'b0);
    load_entry(6'd5, 16'hFFFF,  16'hFFFF,  16'd40000, 1'b1);
    load_entry(6'd4, 16'd12345, 16'd54321, 16'd0,     1'b0);
    visit_customer(6'd5, 1'b0);
    visit_customer(6'd4, 1'b1);
    visit_customer(6'd3, 1'b1);
  endtask

  // zero capacity: every visit opens a route until count and distance saturate
  task automatic test_saturation();
    load_entry(6'd10, 16'hFFFF, 16'hFFFF, 16'd1,    1'b0);
    load_entry(6'd11, 16'hFFFF, 16'd0,    16'hFFFF, 1'b1);
    for (int k = 0; k < 135; k++)
      visit_customer($urandom_range(1) ? 6'd10 : 6'd11, k == 134);
  endtask

  // mostly complete tours with random content, some stray table writes
  task automatic test_random_tours(input int n);
    int start;
    int len;
    start = n_items;
    while (loaded_list.size() < 6) load_random_entry();
    while (n_items - start < n) begin
      if ($urandom_range(99) < 12) begin
        load_random_entry();
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 10) load_random_entry();
          visit_customer(pick_loaded(), k == len - 1);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_idling(IDLE_NONE);

    test_reset_defaults();
    wait_until_quiet();
    apply_config(18'd40000, 16'hFFFF, 16'd0);
    test_capacity_boundaries();
    wait_until_quiet();
    apply_config(18'd0, 16'd0, 16'd0);
    test_saturation();

    for (int seg = 0; seg < 8; seg++) begin
      wait_until_quiet();
      case (seg)
        0: apply_config(18'h3FFFF, 16'hFFFF, 16'hFFFF);
        1: apply_config(18'd0, 16'd0, 16'd0);
        2: apply_config(18'($urandom_range(262143)), pick_coord(), pick_coord());
        3: apply_config(CAPACITY_RESET, 16'd0, 16'hFFFF);
        4: apply_config(18'($urandom_range(70000, 20000)), pick_coord(), pick_coord());
        5: apply_config(18'd65535, 16'hFFFF, 16'd0);
        6: apply_config(18'($urandom_range(262143)), 16'($urandom), 16'($urandom));
        default: apply_config(18'd40000, 16'd32768, 16'd32768);
      endcase
      set_idling(idle_mode_t'(seg % 4));
      test_random_tours(72);
    end

    wait_until_quiet();
    $display("run covered %0d items: %0d table loads, %0d visits, %0d tour scores checked",
             n_items, n_loads, n_visits, n_scores);
    $display("%0d register writes over %0d settings, four idling modes, %0d mismatches",
             n_cfg_writes, n_settings, n_mismatch);
    if (n_mismatch == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
hdl/crce_pkg.sv
hdl/crce_ram.sv
hdl/crce_leg_unit.sv
hdl/capacitated_route_cost_evaluator_core.sv
tb/sv/testbench.sv
